FILE: rtl/core/escaped_frame_receiver_xor_core_assert.svh
// Assertion macros used by the deframer back end
`ifndef ESCAPED_FRAME_RECEIVER_XOR_CORE_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_XOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define EFRX_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define EFRX_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define EFRX_ASSERT(name, clk, rstn, prop, msg)
`define EFRX_ASSERT_NEVER(name, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/core/efrx_pkg.sv
// Shared types and constants of the escaped frame receiver
package efrx_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [CfgIdxW-1:0] CFG_FLAG_BYTE       = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_BYTE     = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_CODE_FOR_FLAG   = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_CODE_FOR_ESCAPE = 4'd3;

  localparam logic [ByteW-1:0] FLAG_RESET       = 8'd255;
  localparam logic [ByteW-1:0] ESCAPE_RESET     = 8'd254;
  localparam logic [ByteW-1:0] CODE_FLAG_RESET  = 8'd1;
  localparam logic [ByteW-1:0] CODE_ESC_RESET   = 8'd0;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_BODY1,
    OP_BODY2,
    OP_CLOSE,
    OP_ESC_CLOSE
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
  } op_t;

endpackage

FILE: rtl/core/escaped_frame_receiver_xor_core.sv
// Top level of the byte-stuffed frame receiver with XOR checksum
//
// Channel   Direction  Handshake                  Payload
// rx        in         rx_valid_i / rx_ready_o    rx_byte_i
// out       out        out_valid_o / out_ready_i  frame_byte_out_o, is_first_o,
//                                                 is_last_o, frame_status_o
// cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// One received byte per cycle enters the front end while rx_ready_o is high;
// results leave one per cycle while out_ready_i is high, and escape pairs that
// expand to two results hold the back end for both. A result passes the op queue,
// then the out register. rx_ready_o drops only when the two-entry op queue is full.
// Reset is asynchronous, active low; no clearing pass is needed.
module escaped_frame_receiver_xor_core import efrx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   frame_byte_out_o,
  output logic               is_first_o,
  output logic               is_last_o,
  output logic [1:0]         frame_status_o
);

  logic q_ready, q_push, q_valid, q_pop;
  op_t  q_op, q_head;

  efrx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_op_o      (q_op)
  );

  efrx_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_op),
    .ready_o   (q_ready),
    .valid_o   (q_valid),
    .head_o    (q_head),
    .pop_i     (q_pop)
  );

  efrx_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_head_i         (q_head),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_out_o (frame_byte_out_o),
    .is_first_o       (is_first_o),
    .is_last_o        (is_last_o),
    .frame_status_o   (frame_status_o)
  );

endmodule

FILE: rtl/core/efrx_front.sv
// Front end: configuration registers, framing state and byte classification
module efrx_front import efrx_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output op_t                q_op_o
);

  logic [ByteW-1:0] flag_q, esc_q, cflag_q, cesc_q;
  logic             inside_q, inside_d;
  logic             waiting_q, waiting_d;
  logic             accept;
  logic             push;
  op_t              op;

  assign rx_ready_o = q_ready_i;
  assign accept     = rx_valid_i && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q  <= FLAG_RESET;
      esc_q   <= ESCAPE_RESET;
      cflag_q <= CODE_FLAG_RESET;
      cesc_q  <= CODE_ESC_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FLAG_BYTE:       flag_q  <= cfg_wdata_i;
        CFG_ESCAPE_BYTE:     esc_q   <= cfg_wdata_i;
        CFG_CODE_FOR_FLAG:   cflag_q <= cfg_wdata_i;
        CFG_CODE_FOR_ESCAPE: cesc_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    inside_d  = inside_q;
    waiting_d = waiting_q;
    push      = 1'b0;
    op.kind   = OP_BODY1;
    op.b0     = rx_byte_i;
    op.b1     = rx_byte_i;
    if (!inside_q) begin
      if (rx_byte_i == flag_q) begin
        push      = 1'b1;
        op.kind   = OP_OPEN;
        inside_d  = 1'b1;
        waiting_d = 1'b0;
      end
    end else if (rx_byte_i == flag_q) begin
      push      = 1'b1;
      inside_d  = 1'b0;
      waiting_d = 1'b0;
      if (waiting_q) begin
        op.kind = OP_ESC_CLOSE;
        op.b0   = esc_q;
      end else begin
        op.kind = OP_CLOSE;
      end
    end else if (waiting_q) begin
      push = 1'b1;
      if (rx_byte_i == cflag_q) begin
        op.b0     = flag_q;
        waiting_d = 1'b0;
      end else if (rx_byte_i == cesc_q) begin
        op.b0     = esc_q;
        waiting_d = 1'b0;
      end else if (rx_byte_i == esc_q) begin
        op.b0 = esc_q;
      end else begin
        op.kind   = OP_BODY2;
        op.b0     = esc_q;
        waiting_d = 1'b0;
      end
    end else if (rx_byte_i == esc_q) begin
      waiting_d = 1'b1;
    end else begin
      push = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      waiting_q <= 1'b0;
    end else if (accept) begin
      inside_q  <= inside_d;
      waiting_q <= waiting_d;
    end
  end

  assign q_push_o = accept && push;
  assign q_op_o   = op;

endmodule

FILE: rtl/core/efrx_fifo.sv
// Two-entry operation queue between front and back end
module efrx_fifo import efrx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic ready_o,
  output logic valid_o,
  output op_t  head_o,
  input  logic pop_i
);

  op_t        mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/efrx_back.sv
// Back end: checksum, body count and the registered result stage
module efrx_back import efrx_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  op_t              q_head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] frame_byte_out_o,
  output logic             is_first_o,
  output logic             is_last_o,
  output logic [1:0]       frame_status_o
);

  `include "escaped_frame_receiver_xor_core_assert.svh"

  logic             out_valid_q;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             first_q, first_d;
  logic             last_q, last_d;
  status_e          status_q, status_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             step_q, step_d;
  logic             load, fire;
  logic             pop;
  logic             is_body, is_close;
  status_e          close_status;

  assign load = !out_valid_q || out_ready_i;
  assign fire = load && q_valid_i;

  always_comb begin
    if (cnt_q != 2'd2) begin
      close_status = ST_SHORT;
    end else if (xor_q != '0) begin
      close_status = ST_BAD_SUM;
    end else begin
      close_status = ST_OK;
    end
  end

  always_comb begin
    pop      = 1'b1;
    step_d   = 1'b0;
    is_body  = 1'b0;
    is_close = 1'b0;
    byte_d   = q_head_i.b0;
    first_d  = 1'b0;
    case (q_head_i.kind)
      OP_OPEN: begin
        first_d = 1'b1;
      end
      OP_BODY1: begin
        is_body = 1'b1;
      end
      OP_BODY2: begin
        is_body = 1'b1;
        if (step_q) begin
          byte_d = q_head_i.b1;
        end else begin
          pop    = 1'b0;
          step_d = 1'b1;
        end
      end
      OP_CLOSE: begin
        is_close = 1'b1;
      end
      OP_ESC_CLOSE: begin
        if (step_q) begin
          byte_d   = q_head_i.b1;
          is_close = 1'b1;
        end else begin
          is_body = 1'b1;
          pop     = 1'b0;
          step_d  = 1'b1;
        end
      end
      default: ;
    endcase
    last_d   = is_close;
    status_d = is_close ? close_status : ST_OK;
  end

  always_comb begin
    xor_d = xor_q;
    cnt_d = cnt_q;
    if (is_body) begin
      if (cnt_q != 2'd0) begin
        xor_d = xor_q ^ byte_d;
      end
      if (cnt_q != 2'd2) begin
        cnt_d = cnt_q + 2'd1;
      end
    end else begin
      xor_d = '0;
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 1'b0;
      xor_q       <= '0;
      cnt_q       <= 2'd0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        step_q      <= step_d;
        xor_q       <= xor_d;
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q   <= byte_d;
      first_q  <= first_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  assign q_pop_o          = fire && pop;
  assign out_valid_o      = out_valid_q;
  assign frame_byte_out_o = byte_q;
  assign is_first_o       = first_q;
  assign is_last_o        = last_q;
  assign frame_status_o   = status_q;

  `EFRX_ASSERT(a_step_two_part, clk_i, rst_ni,
    step_q |-> (q_valid_i && (q_head_i.kind == OP_BODY2 || q_head_i.kind == OP_ESC_CLOSE)),
    "second step pending without a two-result operation")
  `EFRX_ASSERT_NEVER(a_first_last, clk_i, rst_ni, out_valid_q && first_q && last_q,
    "item marked both first and last")
  `EFRX_ASSERT(a_status_last, clk_i, rst_ni,
    (out_valid_q && !last_q) |-> (status_q == ST_OK),
    "status set on an item that is not last")
  `EFRX_ASSERT_NEVER(a_cnt_sat, clk_i, rst_ni, cnt_q == 2'd3,
    "body count past saturation")
  `EFRX_ASSERT(a_pop_fire, clk_i, rst_ni, q_pop_o |=> out_valid_q,
    "operation retired without a result")

endmodule
